@@ hdl/cau_pkg.sv @@
// ============================================================================
// cau_pkg: shared types and constants for the complex arithmetic unit
// Request and result formats, operation and status codes, CORDIC arctangent
// table.
// ============================================================================
`default_nettype none

package cau_pkg;

    // Operation codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_POLAR = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Quotient bits kept by the divider (enough to detect 16-bit overflow)
    localparam int DIV_STEPS = 17;
    // Result bits of the integer square root
    localparam int SQ_STEPS  = 16;
    // CORDIC operand pre-scale and angle fraction bits
    localparam int PRE_SCALE = 8;
    localparam int ANG_FRAC  = 16;
    // CORDIC datapath widths
    localparam int XW = 26;
    localparam int ZW = 25;
    // 90 degrees with ANG_FRAC fraction bits
    localparam logic [22:0] ANG_90 = 23'd5898240;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] a_real;
        logic signed [15:0] a_imag;
        logic signed [15:0] b_real;
        logic signed [15:0] b_imag;
    } req_t;

    typedef struct packed {
        logic signed [15:0] res_first;
        logic signed [15:0] res_second;
        logic [1:0]         status;
    } res_t;

    // atan(2^-i) in degrees, ANG_FRAC fraction bits
    function automatic logic [21:0] cau_atan_deg(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/complex_arithmetic_unit.sv @@
// ============================================================================
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply, divide and polar conversion in
// signed fixed point with saturation and status.
// ============================================================================
// Stages: input, product, setup, one stage per divider/root/CORDIC step,
//   output register.
// Throughput: one request per cycle while the skid slot is empty;
//   the step count sets depth, not rate.
// Reset (aresetn low, synchronous): all valid bits clear, pipeline empties.
// ============================================================================
`default_nettype none

module complex_arithmetic_unit #(
    parameter int FRAC_BITS    = 8,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire cau_pkg::req_t   s_req,
    output logic                 m_valid,
    input  wire                  m_ready,
    output cau_pkg::res_t        m_res
);
    import cau_pkg::*;

    // Number of iteration stages: long enough for the divider, the root and
    // the CORDIC, all of which run side by side on every request.
    localparam int NS      = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;
    // Remainder width: holds |numerator| << FRAC_BITS and den << DIV_STEPS
    localparam int DIV_W   = (32 + FRAC_BITS > 49) ? 32 + FRAC_BITS : 49;
    // Phase rounding from ANG_FRAC down to FRAC_BITS fraction bits
    localparam int RND_SH  = ANG_FRAC - FRAC_BITS;
    localparam logic [23:0] RND_HALF = 24'(1) << (RND_SH - 1);
    localparam logic signed [33:0] MUL_HALF = 34'sd1 <<< (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Saturation helpers
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767)       r = 16'sh7fff;
        else if (v < -40'sd32768) r = -16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic ovf16(input logic signed [39:0] v);
        return (v > 40'sd32767) || (v < -40'sd32768);
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control: the whole pipe advances unless the skid slot of the
    // output buffer is occupied, so ready is a flop and never waits on m_ready
    // combinationally.
    // ------------------------------------------------------------------
    logic en;
    logic in_vld_reg;
    logic pr_vld_reg;
    logic [NS:0] it_vld_reg;
    logic push;
    logic m_valid_reg;
    logic skid_vld_reg;
    res_t m_res_reg;
    res_t skid_res_reg;

    assign en      = !skid_vld_reg;
    assign s_ready = en;
    assign push    = en && it_vld_reg[NS];

    // ------------------------------------------------------------------
    // Stage 0: register the request
    // ------------------------------------------------------------------
    req_t in_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_req;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products, add/subtract with saturation
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] pp_rr;
        logic signed [31:0] pp_ii;
        logic signed [31:0] pp_ri;
        logic signed [31:0] pp_ir;
        logic signed [31:0] sq_ar;
        logic signed [31:0] sq_ai;
        logic signed [31:0] sq_br;
        logic signed [31:0] sq_bi;
        logic signed [15:0] as1;
        logic signed [15:0] as2;
        logic               as_sat;
        logic signed [15:0] a_real;
        logic signed [15:0] a_imag;
    } prod_t;

    prod_t pr_reg;
    prod_t pr_next;

    always_comb begin
        logic signed [39:0] s1;
        logic signed [39:0] s2;
        if (in_reg.req_type == OP_SUB) begin
            s1 = 40'(in_reg.a_real) - 40'(in_reg.b_real);
            s2 = 40'(in_reg.a_imag) - 40'(in_reg.b_imag);
        end else begin
            s1 = 40'(in_reg.a_real) + 40'(in_reg.b_real);
            s2 = 40'(in_reg.a_imag) + 40'(in_reg.b_imag);
        end
        pr_next.op     = in_reg.req_type;
        pr_next.pp_rr  = in_reg.a_real * in_reg.b_real;
        pr_next.pp_ii  = in_reg.a_imag * in_reg.b_imag;
        pr_next.pp_ri  = in_reg.a_real * in_reg.b_imag;
        pr_next.pp_ir  = in_reg.a_imag * in_reg.b_real;
        pr_next.sq_ar  = in_reg.a_real * in_reg.a_real;
        pr_next.sq_ai  = in_reg.a_imag * in_reg.a_imag;
        pr_next.sq_br  = in_reg.b_real * in_reg.b_real;
        pr_next.sq_bi  = in_reg.b_imag * in_reg.b_imag;
        pr_next.as1    = sat16(s1);
        pr_next.as2    = sat16(s2);
        pr_next.as_sat = ovf16(s1) || ovf16(s2);
        pr_next.a_real = in_reg.a_real;
        pr_next.a_imag = in_reg.a_imag;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg <= pr_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: setup of the iterative units
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [2:0]                op;
        logic signed [15:0]        s1;
        logic signed [15:0]        s2;
        logic                      s_sat;
        logic                      dz;
        logic                      neg_re;
        logic                      neg_im;
        logic                      ovf_re;
        logic                      ovf_im;
        logic [DIV_W-1:0]          rem_re;
        logic [DIV_W-1:0]          rem_im;
        logic [31:0]               den;
        logic [DIV_STEPS-1:0]      q_re;
        logic [DIV_STEPS-1:0]      q_im;
        logic [31:0]               sq_n;
        logic [31:0]               sq_r;
        logic signed [XW-1:0]      cx;
        logic signed [XW-1:0]      cy;
        logic signed [ZW-1:0]      cz;
        logic                      ar_zero;
        logic                      ai_zero;
        logic                      ph_neg;
    } it_t;

    it_t it_reg  [0:NS];
    it_t it_next [0:NS-1];
    it_t init_next;

    always_comb begin
        logic signed [33:0] m1;
        logic signed [33:0] m2;
        logic signed [39:0] m1s;
        logic signed [39:0] m2s;
        logic signed [32:0] nre;
        logic signed [32:0] nim;
        logic [32:0]        are;
        logic [32:0]        aim;
        logic [DIV_W-1:0]   dlim;
        logic signed [16:0] xr;
        logic signed [16:0] xi;
        logic signed [16:0] axr;
        logic signed [16:0] axi;

        // Multiply: round half up, then saturate
        m1  = 34'(pr_reg.pp_rr) - 34'(pr_reg.pp_ii) + MUL_HALF;
        m2  = 34'(pr_reg.pp_ri) + 34'(pr_reg.pp_ir) + MUL_HALF;
        m1s = 40'(m1 >>> FRAC_BITS);
        m2s = 40'(m2 >>> FRAC_BITS);

        init_next.op = pr_reg.op;
        if (pr_reg.op == OP_MUL) begin
            init_next.s1    = sat16(m1s);
            init_next.s2    = sat16(m2s);
            init_next.s_sat = ovf16(m1s) || ovf16(m2s);
        end else begin
            init_next.s1    = pr_reg.as1;
            init_next.s2    = pr_reg.as2;
            init_next.s_sat = pr_reg.as_sat;
        end

        // Divide: sign and magnitude of both numerators
        nre = 33'(pr_reg.pp_rr) + 33'(pr_reg.pp_ii);
        nim = 33'(pr_reg.pp_ir) - 33'(pr_reg.pp_ri);
        are = nre[32] ? 33'(-nre) : 33'(nre);
        aim = nim[32] ? 33'(-nim) : 33'(nim);
        init_next.den    = 32'($unsigned(pr_reg.sq_br)) + 32'($unsigned(pr_reg.sq_bi));
        init_next.dz     = (init_next.den == 32'd0);
        init_next.neg_re = nre[32];
        init_next.neg_im = nim[32];
        init_next.rem_re = DIV_W'(are) << FRAC_BITS;
        init_next.rem_im = DIV_W'(aim) << FRAC_BITS;
        dlim             = DIV_W'(init_next.den) << DIV_STEPS;
        init_next.ovf_re = (init_next.rem_re >= dlim);
        init_next.ovf_im = (init_next.rem_im >= dlim);
        init_next.q_re   = '0;
        init_next.q_im   = '0;

        // Square root radicand
        init_next.sq_n = 32'($unsigned(pr_reg.sq_ar)) + 32'($unsigned(pr_reg.sq_ai));
        init_next.sq_r = '0;

        // CORDIC on the first quadrant
        xr  = 17'(pr_reg.a_real);
        xi  = 17'(pr_reg.a_imag);
        axr = xr[16] ? -xr : xr;
        axi = xi[16] ? -xi : xi;
        init_next.cx      = XW'(axr) <<< PRE_SCALE;
        init_next.cy      = XW'(axi) <<< PRE_SCALE;
        init_next.cz      = '0;
        init_next.ar_zero = (pr_reg.a_real == 16'sd0);
        init_next.ai_zero = (pr_reg.a_imag == 16'sd0);
        init_next.ph_neg  = init_next.ar_zero ? xi[16] : (xr[16] != xi[16]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it_reg[0] <= init_next;
        end
    end

    // ------------------------------------------------------------------
    // Iteration stages: up to one divider bit, one root bit and one CORDIC step each
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NS; k++) begin : g_it
        localparam int QSH = (k < DIV_STEPS) ? DIV_STEPS - 1 - k : 0;
        localparam int SQB = (k < SQ_STEPS) ? 30 - 2 * k : 0;

        logic [DIV_W-1:0]     dsh;
        logic [32:0]          sq_t;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;

        assign dsh  = DIV_W'(it_reg[k].den) << QSH;
        assign sq_t = {1'b0, it_reg[k].sq_r} + (33'(1) << SQB);
        assign dx   = it_reg[k].cy >>> k;
        assign dy   = it_reg[k].cx >>> k;
        assign at   = $signed({3'b000, cau_atan_deg(5'(k))});

        always_comb begin
            it_next[k] = it_reg[k];
            if (k < DIV_STEPS) begin
                if (it_reg[k].rem_re >= dsh) begin
                    it_next[k].rem_re    = it_reg[k].rem_re - dsh;
                    it_next[k].q_re[QSH] = 1'b1;
                end
                if (it_reg[k].rem_im >= dsh) begin
                    it_next[k].rem_im    = it_reg[k].rem_im - dsh;
                    it_next[k].q_im[QSH] = 1'b1;
                end
            end
            if (k < SQ_STEPS) begin
                if ({1'b0, it_reg[k].sq_n} >= sq_t) begin
                    it_next[k].sq_n = it_reg[k].sq_n - sq_t[31:0];
                    it_next[k].sq_r = (it_reg[k].sq_r >> 1) + (32'(1) << SQB);
                end else begin
                    it_next[k].sq_r = it_reg[k].sq_r >> 1;
                end
            end
            if (k < CORDIC_STEPS) begin
                if (it_reg[k].cy > 0) begin
                    it_next[k].cx = it_reg[k].cx + dx;
                    it_next[k].cy = it_reg[k].cy - dy;
                    it_next[k].cz = it_reg[k].cz + at;
                end else begin
                    it_next[k].cx = it_reg[k].cx - dx;
                    it_next[k].cy = it_reg[k].cy + dy;
                    it_next[k].cz = it_reg[k].cz - at;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                it_reg[k+1] <= it_next[k];
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            pr_vld_reg <= 1'b0;
            it_vld_reg <= '0;
        end else if (en) begin
            in_vld_reg <= s_valid;
            pr_vld_reg <= in_vld_reg;
            it_vld_reg <= {it_vld_reg[NS-1:0], pr_vld_reg};
        end
    end

    // ------------------------------------------------------------------
    // Final formatting: saturate quotients and magnitude, round the phase,
    // select by operation.
    // ------------------------------------------------------------------
    res_t p_res;

    always_comb begin
        it_t                 f;
        logic                dsat_re;
        logic                dsat_im;
        logic signed [17:0]  qv_re;
        logic signed [17:0]  qv_im;
        logic signed [15:0]  d_re;
        logic signed [15:0]  d_im;
        logic signed [15:0]  mag;
        logic                mag_sat;
        logic [22:0]         zc;
        logic [23:0]         zr;
        logic signed [39:0]  ph;

        f = it_reg[NS];

        qv_re   = f.neg_re ? -$signed({1'b0, f.q_re}) : $signed({1'b0, f.q_re});
        qv_im   = f.neg_im ? -$signed({1'b0, f.q_im}) : $signed({1'b0, f.q_im});
        dsat_re = f.ovf_re || ovf16(40'(qv_re));
        dsat_im = f.ovf_im || ovf16(40'(qv_im));
        d_re    = f.ovf_re ? (f.neg_re ? -16'sh8000 : 16'sh7fff) : sat16(40'(qv_re));
        d_im    = f.ovf_im ? (f.neg_im ? -16'sh8000 : 16'sh7fff) : sat16(40'(qv_im));

        mag_sat = (f.sq_r > 32'd32767);
        mag     = mag_sat ? 16'sh7fff : f.sq_r[15:0];

        // Clamp the angle to 0..90 degrees; axis cases take fixed angles
        if (f.ar_zero)             zc = ANG_90;
        else if (f.ai_zero)        zc = '0;
        else if (f.cz < 0)         zc = '0;
        else if (f.cz > $signed({2'b00, ANG_90})) zc = ANG_90;
        else                       zc = f.cz[22:0];
        zr = (24'(zc) + RND_HALF) >> RND_SH;
        ph = f.ph_neg ? -40'(zr) : 40'(zr);

        p_res.res_first  = '0;
        p_res.res_second = '0;
        p_res.status     = ST_OK;
        case (f.op)
            OP_ADD, OP_SUB, OP_MUL: begin
                p_res.res_first  = f.s1;
                p_res.res_second = f.s2;
                p_res.status     = f.s_sat ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (f.dz) begin
                    p_res.status = ST_ZERO;
                end else begin
                    p_res.res_first  = d_re;
                    p_res.res_second = d_im;
                    p_res.status     = (dsat_re || dsat_im) ? ST_SAT : ST_OK;
                end
            end
            OP_POLAR: begin
                if (f.ar_zero && f.ai_zero) begin
                    p_res.status = ST_ZERO;
                end else begin
                    p_res.res_first  = mag;
                    p_res.res_second = sat16(ph);
                    p_res.status     = (mag_sat || ovf16(ph)) ? ST_SAT : ST_OK;
                end
            end
            default: begin
                p_res.status = ST_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register with skid slot: a finished request that cannot leave
    // parks in the skid slot, and only then does the pipe hold.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            // Output slot frees: drain the skid slot first
            if (skid_vld_reg) begin
                m_valid_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_valid_reg <= push;
            end
        end else if (push) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_res_reg <= skid_vld_reg ? skid_res_reg : p_res;
        end else if (push) begin
            skid_res_reg <= p_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

`default_nettype wire

@@ dv/complex_arithmetic_unit_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// complex_arithmetic_unit_tb: self-checking bench for the complex unit
// Drives directed and random requests through the valid/ready input channel,
// predicts each result in the bench and compares it against the result
// channel in order, with random idle bursts on both sides.
// ============================================================================
`default_nettype none

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int FRAC_BITS    = 8;
    localparam int CORDIC_STEPS = 16;
    localparam int N_RANDOM     = 650;
    localparam int QUIET_TAIL   = 100;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_req;
    logic m_valid;
    logic m_ready;
    res_t m_res;

    req_t pending_reqs[$];
    res_t expected_results[$];
    int   error_count;
    bit   stim_done;
    int   s_idle;
    int   m_idle;

    complex_arithmetic_unit #(
        .FRAC_BITS(FRAC_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req(s_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_res(m_res)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // floor(v / 2^s), valid for negative v as well
    function automatic longint floor_div_pow2(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp16(longint v, ref bit hit);
        if (v > 32767) begin
            hit = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            hit = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint atan_step_deg(int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                            58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                            229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic longint cordic_phase(longint ar, longint ai);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint p;
        x = (ar < 0 ? -ar : ar) <<< PRE_SCALE;
        y = (ai < 0 ? -ai : ai) <<< PRE_SCALE;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = floor_div_pow2(y, i);
            dy = floor_div_pow2(x, i);
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += atan_step_deg(i);
            end else begin
                x -= dx;
                y += dy;
                z -= atan_step_deg(i);
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd90 <<< ANG_FRAC)) z = 64'sd90 <<< ANG_FRAC;
        p = floor_div_pow2(z + (64'sd1 <<< (ANG_FRAC - FRAC_BITS - 1)),
                           ANG_FRAC - FRAC_BITS);
        return ((ar < 0) != (ai < 0)) ? -p : p;
    endfunction

    function automatic res_t complex_result(req_t rq);
        longint ar;
        longint ai;
        longint br;
        longint bi;
        longint r1;
        longint r2;
        longint den;
        logic [1:0] st;
        bit hit;
        res_t rs;
        ar = rq.a_real;
        ai = rq.a_imag;
        br = rq.b_real;
        bi = rq.b_imag;
        r1 = 0;
        r2 = 0;
        st = ST_OK;
        hit = 1'b0;
        case (rq.req_type)
            OP_ADD: begin
                r1 = clamp16(ar + br, hit);
                r2 = clamp16(ai + bi, hit);
            end
            OP_SUB: begin
                r1 = clamp16(ar - br, hit);
                r2 = clamp16(ai - bi, hit);
            end
            OP_MUL: begin
                r1 = clamp16(floor_div_pow2(ar * br - ai * bi
                             + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS), hit);
                r2 = clamp16(floor_div_pow2(ar * bi + ai * br
                             + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS), hit);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    st = ST_ZERO;
                end else begin
                    r1 = clamp16(((ar * br + ai * bi) <<< FRAC_BITS) / den, hit);
                    r2 = clamp16(((ai * br - ar * bi) <<< FRAC_BITS) / den, hit);
                end
            end
            OP_POLAR: begin
                if (ar == 0 && ai == 0) begin
                    st = ST_ZERO;
                end else begin
                    r1 = clamp16(int_sqrt(ar * ar + ai * ai), hit);
                    if (ar == 0) r2 = (ai > 0 ? 90 : -90) <<< FRAC_BITS;
                    else if (ai == 0) r2 = 0;
                    else r2 = cordic_phase(ar, ai);
                    r2 = clamp16(r2, hit);
                end
            end
            default: ;
        endcase
        if (st == ST_OK && hit) st = ST_SAT;
        rs.res_first = r1[15:0];
        rs.res_second = r2[15:0];
        rs.status = st;
        return rs;
    endfunction

    function automatic req_t make_req(logic [2:0] op, logic [15:0] ar,
                                      logic [15:0] ai, logic [15:0] br,
                                      logic [15:0] bi);
        req_t rq;
        rq.req_type = op;
        rq.a_real = ar;
        rq.a_imag = ai;
        rq.b_real = br;
        rq.b_imag = bi;
        return rq;
    endfunction

    // Mostly small operands so divide and multiply land in range, some full
    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3, 4: return 16'($urandom_range(0, 65535));
            default: return 16'($signed($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    // Fill the request queue: directed corners first, then random traffic
    initial begin
        pending_reqs.push_back(make_req(OP_ADD, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF));
        pending_reqs.push_back(make_req(OP_ADD, 16'h0100, 16'h0200, 16'h0300, 16'hFF00));
        pending_reqs.push_back(make_req(OP_SUB, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF));
        pending_reqs.push_back(make_req(OP_SUB, 16'h0500, 16'h0100, 16'h0200, 16'h0300));
        pending_reqs.push_back(make_req(OP_MUL, 16'h0180, 16'hFF80, 16'h0200, 16'h0100));
        pending_reqs.push_back(make_req(OP_MUL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
        pending_reqs.push_back(make_req(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        pending_reqs.push_back(make_req(OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000));
        pending_reqs.push_back(make_req(OP_DIV, 16'h0300, 16'hFE00, 16'h0100, 16'h0100));
        pending_reqs.push_back(make_req(OP_DIV, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000));
        pending_reqs.push_back(make_req(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF));
        pending_reqs.push_back(make_req(OP_POLAR, 16'h0000, 16'h0000, 16'h1234, 16'h4321));
        pending_reqs.push_back(make_req(OP_POLAR, 16'h0000, 16'h0300, 16'h0, 16'h0));
        pending_reqs.push_back(make_req(OP_POLAR, 16'h0000, 16'hFD00, 16'h0, 16'h0));
        pending_reqs.push_back(make_req(OP_POLAR, 16'hFD00, 16'h0000, 16'h0, 16'h0));
        pending_reqs.push_back(make_req(OP_POLAR, 16'h0300, 16'h0400, 16'h0, 16'h0));
        pending_reqs.push_back(make_req(OP_POLAR, 16'hFD00, 16'h0400, 16'h0, 16'h0));
        pending_reqs.push_back(make_req(OP_POLAR, 16'h8000, 16'h8000, 16'h0, 16'h0));
        pending_reqs.push_back(make_req(OP_POLAR, 16'h7FFF, 16'h0001, 16'h0, 16'h0));
        pending_reqs.push_back(make_req(3'd5, 16'h1111, 16'h2222, 16'h3333, 16'h4444));
        pending_reqs.push_back(make_req(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        for (int i = 0; i < N_RANDOM; i++) begin
            pending_reqs.push_back(make_req(
                ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4)),
                rand_operand(), rand_operand(), rand_operand(), rand_operand()));
        end
        stim_done = 1'b1;
    end

    initial begin
        error_count = 0;
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: hold the request until accepted, then advance or idle a burst
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_req <= '0;
            s_idle <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_results.push_back(complex_result(s_req));
            if (s_idle > 0) begin
                s_idle <= s_idle - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_req <= pending_reqs.pop_front();
                s_valid <= 1'b1;
                // Drop idling for the last stretch of requests
                if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    s_idle <= $urandom_range(1, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_idle <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_res);
                    error_count++;
                end else begin
                    res_t exp_res;
                    exp_res = expected_results.pop_front();
                    if (m_res.res_first !== exp_res.res_first) begin
                        $display("%0t: res_first expected %h actual %h", $time,
                                 exp_res.res_first, m_res.res_first);
                        error_count++;
                    end
                    if (m_res.res_second !== exp_res.res_second) begin
                        $display("%0t: res_second expected %h actual %h", $time,
                                 exp_res.res_second, m_res.res_second);
                        error_count++;
                    end
                    if (m_res.status !== exp_res.status) begin
                        $display("%0t: status expected %h actual %h", $time,
                                 exp_res.status, m_res.status);
                        error_count++;
                    end
                end
            end
            // Stall in bursts, except once the sender reaches its tail
            if (m_idle > 0) begin
                m_idle <= m_idle - 1;
                m_ready <= 1'b0;
            end else if (pending_reqs.size() > QUIET_TAIL &&
                         $urandom_range(0, 5) == 0) begin
                m_idle <= $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Wait until every request is in and every result is out, then drain
    initial begin
        wait (stim_done && aresetn);
        @(posedge aclk);
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ complex_arithmetic_unit.f @@
hdl/cau_pkg.sv
hdl/complex_arithmetic_unit.sv
dv/complex_arithmetic_unit_tb.sv
